// File: rtl/core/tsf_pkg.sv
package tsf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_SPANS = 64;
    localparam int COORD_W   = 12;
    localparam int OUT_W     = 11;
    localparam int FIX_W     = 32;
    localparam int DX_W      = COORD_W + 1;
    localparam int NUM_W     = DX_W + FRAC_BITS + 2;
    localparam int DIV_W     = NUM_W - 1;
    localparam int DEN_W     = COORD_W + 1;
    localparam int CNT_W     = $clog2(MAX_SPANS + 1);
    localparam int DCNT_W    = $clog2(DIV_W);
    localparam int XI_W      = FIX_W - FRAC_BITS;

    localparam logic [OUT_W-1:0] COORD_MAX = {OUT_W{1'b1}};
    localparam logic signed [FIX_W-1:0] HALF = FIX_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_INIT = 10'b0000000010,
        S_ROW  = 10'b0000000100,
        S_CHK  = 10'b0000001000,
        S_WALK = 10'b0000010000,
        S_DIV  = 10'b0000100000,
        S_SWAP = 10'b0001000000,
        S_EMIT = 10'b0010000000,
        S_ADV  = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic row_start;
        logic next_edge;
        logic walk_start;
        logic walk_step;
        logic div_start;
        logic edge_write;
        logic swap;
        logic set_trunc;
        logic emit;
        logic adv;
        logic fin_push;
    } cmd_t;

    typedef struct packed {
        logic row_refresh;
        logic need_edge;
        logic edge_sel;
        logic walk_break;
        logic walk_fail;
        logic div_done;
        logic span_hit;
        logic cap_full;
        logic slot_free;
        logic pending_valid;
        logic at_ymax;
    } status_t;

    // forward edge walks +1, backward edge walks +2 (mod 3)
    function automatic logic [1:0] next_vtx(input logic [1:0] idx, input logic back);
        logic [1:0] r;
        r = 2'd0;
        if (back) begin
            unique case (idx)
                2'd0:    r = 2'd2;
                2'd1:    r = 2'd0;
                default: r = 2'd1;
            endcase
        end else begin
            unique case (idx)
                2'd0:    r = 2'd1;
                2'd1:    r = 2'd2;
                default: r = 2'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_coord(input logic signed [XI_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(XI_W-OUT_W){1'b0}}, COORD_MAX})) begin
            r = COORD_MAX;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/triangle_scanline_span_fill.sv
// Triangle scanline span fill: takes one triangle (three signed 12-bit vertices) per input
// word and returns one output word per covered scanline, top row first, with m_last on the
// final span and m_truncated when the 64-span cap cut rows off; a triangle covering no
// pixel row produces no words. One triangle is worked at a time: s_ready is high only
// while the sequencer is idle. Each edge change runs a vertex walk and the bit-serial step
// divider; m_ready backpressure can stall output.
module triangle_scanline_span_fill (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_ax,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_ay,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_bx,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_by,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_cx,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_cy,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [tsf_pkg::OUT_W-1:0]             m_row,
    output logic [tsf_pkg::OUT_W-1:0]             m_span_start,
    output logic [tsf_pkg::OUT_W-1:0]             m_span_end,
    output logic                                  m_last,
    output logic                                  m_truncated
);

    tsf_pkg::cmd_t    cmd;
    tsf_pkg::status_t sts;

    tsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tsf_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_bx         (s_bx),
        .s_by         (s_by),
        .s_cx         (s_cx),
        .s_cy         (s_cy),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_row        (m_row),
        .m_span_start (m_span_start),
        .m_span_end   (m_span_end),
        .m_last       (m_last),
        .m_truncated  (m_truncated)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a triangle is in progress");

    a_trunc_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_truncated || m_last))
        else $error("truncated flag on a non-final span");

    a_push_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.pending_valid) || cmd.fin_push |-> sts.slot_free)
        else $error("span pushed over an unread word");

    a_start_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_span_start <= m_span_end))
        else $error("span order");
`endif

endmodule

// File: rtl/core/tsf_div.sv
module tsf_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [tsf_pkg::DIV_W-1:0]           mag,
    input  logic                                neg,
    input  logic [tsf_pkg::DEN_W-1:0]           den,
    output logic                                done,
    output logic signed [tsf_pkg::FIX_W-1:0]    quo
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [tsf_pkg::DCNT_W-1:0]      cnt_reg, cnt_next;
    logic [tsf_pkg::DEN_W-1:0]       rem_reg, rem_next;
    logic [tsf_pkg::DIV_W-1:0]       quo_reg, quo_next;
    logic [tsf_pkg::DEN_W-1:0]       den_reg, den_next;
    logic                            neg_reg, neg_next;
    logic [tsf_pkg::DEN_W:0]         partial;
    logic [tsf_pkg::DEN_W+1:0]       trial;
    logic [tsf_pkg::FIX_W-1:0]       qext;

    assign partial = {rem_reg, quo_reg[tsf_pkg::DIV_W-1]};
    assign trial   = {1'b0, partial} - {2'b00, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = mag;
            den_next  = den;
            neg_next  = neg;
        end else if (busy_reg) begin
            if (!trial[tsf_pkg::DEN_W+1]) begin
                rem_next = trial[tsf_pkg::DEN_W-1:0];
                quo_next = {quo_reg[tsf_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_next = partial[tsf_pkg::DEN_W-1:0];
                quo_next = {quo_reg[tsf_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tsf_pkg::DCNT_W'(tsf_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign qext = {{(tsf_pkg::FIX_W-tsf_pkg::DIV_W){1'b0}}, quo_reg};
    assign quo  = neg_reg ? -$signed(qext) : $signed(qext);
    assign done = done_reg;

endmodule

// File: rtl/core/tsf_datapath.sv
module tsf_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tsf_pkg::cmd_t                         cmd,
    output tsf_pkg::status_t                      sts,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_ax,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_ay,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_bx,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_by,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_cx,
    input  logic signed [tsf_pkg::COORD_W-1:0]    s_cy,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic [tsf_pkg::OUT_W-1:0]             m_row,
    output logic [tsf_pkg::OUT_W-1:0]             m_span_start,
    output logic [tsf_pkg::OUT_W-1:0]             m_span_end,
    output logic                                  m_last,
    output logic                                  m_truncated
);

    localparam int CW = tsf_pkg::COORD_W;
    localparam int FW = tsf_pkg::FIX_W;
    localparam int OW = tsf_pkg::OUT_W;

    logic signed [CW-1:0] vx_reg [3];
    logic signed [CW-1:0] vy_reg [3];
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [FW-1:0] ex_reg [2];
    logic signed [FW-1:0] step_reg [2];
    logic signed [CW-1:0] end_reg [2];
    logic [1:0]           ev_reg [2];
    logic [1:0]           left_cnt_reg, left_cnt_next;
    logic                 esel_reg, esel_next;
    logic                 lft_reg, lft_next;
    logic [1:0]           idx_reg, idx_next;
    logic signed [CW-1:0] xs_reg, xs_next;
    logic [tsf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                 trunc_reg, trunc_next;
    logic                 pv_reg, pv_next;
    logic [OW-1:0]        prow_reg, pst_reg, pend_reg;
    logic                 mv_reg, mv_next;
    logic [OW-1:0]        mrow_reg, mst_reg, mend_reg;
    logic                 mlast_reg, mtr_reg;

    logic signed [CW-1:0] ymin, ymax, ty, vx_idx;
    logic [1:0]           imin;
    logic signed [FW-1:0] ex_l, ex_r, sum_l, sum_r, dquo;
    logic signed [tsf_pkg::XI_W-1:0] x1, x2;
    logic signed [tsf_pkg::DX_W-1:0] dx, dty;
    logic signed [tsf_pkg::NUM_W-1:0] num, nabs;
    logic                 ddone, push;

    always_comb begin
        ymin = vy_reg[0];
        imin = 2'd0;
        if (vy_reg[1] < ymin) begin
            ymin = vy_reg[1];
            imin = 2'd1;
        end
        if (vy_reg[2] < ymin) begin
            ymin = vy_reg[2];
            imin = 2'd2;
        end
        ymax = vy_reg[0];
        if (vy_reg[1] > ymax) ymax = vy_reg[1];
        if (vy_reg[2] > ymax) ymax = vy_reg[2];
    end

    always_comb begin
        unique case (idx_reg)
            2'd1: begin
                ty = vy_reg[1];
                vx_idx = vx_reg[1];
            end
            2'd2: begin
                ty = vy_reg[2];
                vx_idx = vx_reg[2];
            end
            default: begin
                ty = vy_reg[0];
                vx_idx = vx_reg[0];
            end
        endcase
    end

    assign dx   = tsf_pkg::DX_W'(vx_idx) - tsf_pkg::DX_W'(xs_reg);
    assign dty  = tsf_pkg::DX_W'(ty) - tsf_pkg::DX_W'(y_reg);
    assign num  = (tsf_pkg::NUM_W'(dx) <<< (tsf_pkg::FRAC_BITS + 1))
                  + tsf_pkg::NUM_W'(dty);
    assign nabs = num[tsf_pkg::NUM_W-1] ? -num : num;

    tsf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .mag     (nabs[tsf_pkg::DIV_W-1:0]),
        .neg     (num[tsf_pkg::NUM_W-1]),
        .den     ({dty[tsf_pkg::DEN_W-2:0], 1'b0}),
        .done    (ddone),
        .quo     (dquo)
    );

    assign ex_l  = lft_reg ? ex_reg[1] : ex_reg[0];
    assign ex_r  = lft_reg ? ex_reg[0] : ex_reg[1];
    assign sum_l = ex_l + tsf_pkg::HALF;
    assign sum_r = ex_r + tsf_pkg::HALF;
    assign x1    = sum_l[FW-1:tsf_pkg::FRAC_BITS];
    assign x2    = sum_r[FW-1:tsf_pkg::FRAC_BITS];

    assign sts.row_refresh   = (y_reg < ymax) || (y_reg == ymin);
    assign sts.need_edge     = y_reg >= end_reg[esel_reg];
    assign sts.edge_sel      = esel_reg;
    assign sts.walk_break    = (ty > y_reg) || (left_cnt_reg == 2'd0);
    assign sts.walk_fail     = y_reg >= ty;
    assign sts.div_done      = ddone;
    assign sts.span_hit      = !y_reg[CW-1] && !x2[tsf_pkg::XI_W-1];
    assign sts.cap_full      = cnt_reg >= tsf_pkg::CNT_W'(tsf_pkg::MAX_SPANS);
    assign sts.slot_free     = !mv_reg || m_ready;
    assign sts.pending_valid = pv_reg;
    assign sts.at_ymax       = y_reg == ymax;

    assign push = (cmd.emit && pv_reg) || cmd.fin_push;

    always_comb begin
        y_next        = y_reg;
        left_cnt_next = left_cnt_reg;
        esel_next     = esel_reg;
        lft_next      = lft_reg;
        idx_next      = idx_reg;
        xs_next       = xs_reg;
        cnt_next      = cnt_reg;
        trunc_next    = trunc_reg;
        pv_next       = pv_reg;
        mv_next       = mv_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        if (push) mv_next = 1'b1;
        if (cmd.init) begin
            y_next        = ymin;
            left_cnt_next = 2'd3;
            lft_next      = 1'b0;
            cnt_next      = '0;
            trunc_next    = 1'b0;
            pv_next       = 1'b0;
        end
        if (cmd.row_start) esel_next = 1'b0;
        if (cmd.next_edge) esel_next = 1'b1;
        if (cmd.walk_start) begin
            idx_next = ev_reg[esel_reg];
            xs_next  = '0;
        end
        if (cmd.walk_step) begin
            xs_next       = vx_idx;
            idx_next      = tsf_pkg::next_vtx(idx_reg, esel_reg);
            left_cnt_next = left_cnt_reg - 2'd1;
        end
        if (cmd.swap && (ex_l > ex_r)) lft_next = ~lft_reg;
        if (cmd.set_trunc) trunc_next = 1'b1;
        if (cmd.emit) begin
            pv_next  = 1'b1;
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.fin_push) pv_next = 1'b0;
        if (cmd.adv && !sts.at_ymax) y_next = y_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg       <= 1'b0;
            pv_reg       <= 1'b0;
            esel_reg     <= 1'b0;
            lft_reg      <= 1'b0;
            left_cnt_reg <= 2'd3;
            cnt_reg      <= '0;
            trunc_reg    <= 1'b0;
            y_reg        <= '0;
            idx_reg      <= '0;
            xs_reg       <= '0;
        end else begin
            mv_reg       <= mv_next;
            pv_reg       <= pv_next;
            esel_reg     <= esel_next;
            lft_reg      <= lft_next;
            left_cnt_reg <= left_cnt_next;
            cnt_reg      <= cnt_next;
            trunc_reg    <= trunc_next;
            y_reg        <= y_next;
            idx_reg      <= idx_next;
            xs_reg       <= xs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            vx_reg[0] <= s_ax;
            vy_reg[0] <= s_ay;
            vx_reg[1] <= s_bx;
            vy_reg[1] <= s_by;
            vx_reg[2] <= s_cx;
            vy_reg[2] <= s_cy;
        end
        if (cmd.init) begin
            for (int i = 0; i < 2; i++) begin
                ex_reg[i]   <= '0;
                step_reg[i] <= '0;
                end_reg[i]  <= ymin;
                ev_reg[i]   <= imin;
            end
        end else if (cmd.edge_write) begin
            ex_reg[esel_reg]   <= FW'(xs_reg) <<< tsf_pkg::FRAC_BITS;
            step_reg[esel_reg] <= dquo;
            end_reg[esel_reg]  <= ty;
            ev_reg[esel_reg]   <= idx_reg;
        end else if (cmd.adv) begin
            ex_reg[0] <= ex_reg[0] + step_reg[0];
            ex_reg[1] <= ex_reg[1] + step_reg[1];
        end
        if (cmd.emit) begin
            prow_reg <= y_reg[OW-1:0];
            pst_reg  <= tsf_pkg::sat_coord(x1);
            pend_reg <= tsf_pkg::sat_coord(x2);
        end
        if (push) begin
            mrow_reg  <= prow_reg;
            mst_reg   <= pst_reg;
            mend_reg  <= pend_reg;
            mlast_reg <= cmd.fin_push;
            mtr_reg   <= cmd.fin_push && trunc_reg;
        end
    end

    assign m_valid      = mv_reg;
    assign m_row        = mrow_reg;
    assign m_span_start = mst_reg;
    assign m_span_end   = mend_reg;
    assign m_last       = mlast_reg;
    assign m_truncated  = mtr_reg;

endmodule

// File: rtl/core/tsf_ctrl.sv
module tsf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tsf_pkg::status_t  sts,
    output tsf_pkg::cmd_t     cmd
);

    tsf_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            tsf_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = tsf_pkg::S_INIT;
                end
            end
            tsf_pkg::S_INIT: begin
                cmd.init   = 1'b1;
                state_next = tsf_pkg::S_ROW;
            end
            tsf_pkg::S_ROW: begin
                cmd.row_start = 1'b1;
                state_next = sts.row_refresh ? tsf_pkg::S_CHK : tsf_pkg::S_SWAP;
            end
            tsf_pkg::S_CHK: begin
                if (sts.need_edge) begin
                    cmd.walk_start = 1'b1;
                    state_next     = tsf_pkg::S_WALK;
                end else if (sts.edge_sel) begin
                    state_next = tsf_pkg::S_SWAP;
                end else begin
                    cmd.next_edge = 1'b1;
                end
            end
            tsf_pkg::S_WALK: begin
                if (!sts.walk_break) begin
                    cmd.walk_step = 1'b1;
                end else if (sts.walk_fail) begin
                    state_next = tsf_pkg::S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = tsf_pkg::S_DIV;
                end
            end
            tsf_pkg::S_DIV: begin
                if (sts.div_done) begin
                    cmd.edge_write = 1'b1;
                    if (sts.edge_sel) begin
                        state_next = tsf_pkg::S_SWAP;
                    end else begin
                        cmd.next_edge = 1'b1;
                        state_next    = tsf_pkg::S_CHK;
                    end
                end
            end
            tsf_pkg::S_SWAP: begin
                cmd.swap   = 1'b1;
                state_next = tsf_pkg::S_EMIT;
            end
            tsf_pkg::S_EMIT: begin
                priority if (!sts.span_hit) begin
                    state_next = tsf_pkg::S_ADV;
                end else if (sts.cap_full) begin
                    cmd.set_trunc = 1'b1;
                    state_next    = tsf_pkg::S_FIN;
                end else if (!sts.pending_valid || sts.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = tsf_pkg::S_ADV;
                end
            end
            tsf_pkg::S_ADV: begin
                cmd.adv    = 1'b1;
                state_next = sts.at_ymax ? tsf_pkg::S_FIN : tsf_pkg::S_ROW;
            end
            tsf_pkg::S_FIN: begin
                priority if (!sts.pending_valid) begin
                    state_next = tsf_pkg::S_IDLE;
                end else if (sts.slot_free) begin
                    cmd.fin_push = 1'b1;
                    state_next   = tsf_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tsf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tsf_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: tb/tb_triangle_scanline_span_fill.sv
`timescale 1ns / 1ps

module tb_triangle_scanline_span_fill;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int LONG_HOLD      = 3000;
    localparam int TAIL_CYCLES    = 400;

    typedef struct {
        logic signed [tsf_pkg::COORD_W-1:0] ax, ay, bx, by, cx, cy;
        bit                                 drain;
    } tri_t;

    typedef struct {
        logic [tsf_pkg::OUT_W-1:0] row;
        logic [tsf_pkg::OUT_W-1:0] span_start;
        logic [tsf_pkg::OUT_W-1:0] span_end;
        logic                      last;
        logic                      truncated;
    } span_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [tsf_pkg::COORD_W-1:0] s_ax, s_ay, s_bx, s_by, s_cx, s_cy;
    logic m_valid;
    logic m_ready;
    logic [tsf_pkg::OUT_W-1:0] m_row, m_span_start, m_span_end;
    logic m_last, m_truncated;

    tri_t  tri_q[$];
    span_t span_q[$];

    int tri_total;
    int tri_sent;
    int tri_taken;
    int spans_seen;
    int trunc_seen;
    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int hold_left;
    int stall_mode;
    int mode_cycles;
    bit long_hold_done;

    triangle_scanline_span_fill DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_bx         (s_bx),
        .s_by         (s_by),
        .s_cx         (s_cx),
        .s_cy         (s_cy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row        (m_row),
        .m_span_start (m_span_start),
        .m_span_end   (m_span_end),
        .m_last       (m_last),
        .m_truncated  (m_truncated)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [tsf_pkg::OUT_W-1:0] clamp_coord(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > 2047) begin
            return 11'd2047;
        end
        return v[tsf_pkg::OUT_W-1:0];
    endfunction

    // edge walk per triangle, queues every expected span
    task automatic predict_spans(input tri_t t);
        int     vx[3];
        int     vy[3];
        longint ex[2];
        longint es[2];
        int     er[2];
        int     ev[2];
        int     el, cnt, ymin, ymax, y, imin, lft, rgt, i, idx, xs, ty;
        longint num, den, x1, x2;
        bit     trunc, done;
        span_t  sp;
        span_t  spans[$];
        vx[0] = t.ax; vy[0] = t.ay;
        vx[1] = t.bx; vy[1] = t.by;
        vx[2] = t.cx; vy[2] = t.cy;
        ymin = vy[0]; ymax = vy[0]; imin = 0;
        for (i = 0; i < 3; i++) begin
            if (vy[i] < ymin) begin
                ymin = vy[i];
                imin = i;
            end
            if (vy[i] > ymax) ymax = vy[i];
        end
        for (i = 0; i < 2; i++) begin
            ex[i] = 0; es[i] = 0; er[i] = ymin; ev[i] = imin;
        end
        el = 3; cnt = 0; lft = 0; rgt = 1; trunc = 0; done = 0;
        y = ymin;
        while (!done) begin
            if (y < ymax || y == ymin) begin
                for (i = 0; i < 2; i++) begin
                    if (!done && y >= er[i]) begin
                        idx = ev[i];
                        xs = 0;
                        forever begin
                            ty = vy[idx];
                            if (ty > y || el == 0) break;
                            xs = vx[idx];
                            idx = (idx + (i == 0 ? 1 : 2)) % 3;
                            el--;
                        end
                        if (y >= ty) begin
                            done = 1;
                        end else begin
                            num = (longint'(vx[idx]) - xs) * 65536 * 2 + (ty - y);
                            den = 2 * longint'(ty - y);
                            er[i] = ty;
                            es[i] = num / den;
                            ex[i] = longint'(xs) * 65536;
                            ev[i] = idx;
                        end
                    end
                end
            end
            if (!done) begin
                if (ex[lft] > ex[rgt]) begin
                    lft ^= 1;
                    rgt ^= 1;
                end
                if (y >= 0) begin
                    x1 = (ex[lft] + 32768) >>> 16;
                    x2 = (ex[rgt] + 32768) >>> 16;
                    if (x2 >= 0) begin
                        if (cnt >= tsf_pkg::MAX_SPANS) begin
                            trunc = 1;
                            done = 1;
                        end else begin
                            sp.row        = y[tsf_pkg::OUT_W-1:0];
                            sp.span_start = clamp_coord(x1);
                            sp.span_end   = clamp_coord(x2);
                            sp.last       = 1'b0;
                            sp.truncated  = 1'b0;
                            spans.insert(spans.size(), sp);
                            cnt++;
                        end
                    end
                end
                if (!done) begin
                    ex[lft] += es[lft];
                    ex[rgt] += es[rgt];
                    y++;
                    if (y > ymax) done = 1;
                end
            end
        end
        if (cnt > 0) begin
            spans[cnt-1].last      = 1'b1;
            spans[cnt-1].truncated = trunc;
        end
        foreach (spans[k]) span_q.insert(span_q.size(), spans[k]);
    endtask

    function automatic tri_t make_tri(input int ax, ay, bx, by, cx, cy, input bit drain);
        tri_t t;
        t.ax = ax; t.ay = ay; t.bx = bx; t.by = by; t.cx = cx; t.cy = cy;
        t.drain = drain;
        return t;
    endfunction

    function automatic int small_coord(input int base);
        return base + $urandom_range(0, 90) - 20;
    endfunction

    // input acceptance and prediction
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_spans('{s_ax, s_ay, s_bx, s_by, s_cx, s_cy, 1'b0});
            tri_taken <= tri_taken + 1;
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && tri_sent != tri_taken) begin
            // hold until taken
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (tri_q.size() > 0 &&
                     (!tri_q[0].drain || (span_q.size() == 0 && tri_sent == tri_taken))) begin
            s_valid <= 1'b1;
            s_ax <= tri_q[0].ax; s_ay <= tri_q[0].ay;
            s_bx <= tri_q[0].bx; s_by <= tri_q[0].by;
            s_cx <= tri_q[0].cx; s_cy <= tri_q[0].cy;
            void'(tri_q.pop_front());
            tri_sent <= tri_sent + 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 10);
                gap_left   <= (stall_mode == 0) ? 0 : $urandom_range(0, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_cycles == 0) begin
                stall_mode  <= $urandom_range(0, 3);
                mode_cycles <= $urandom_range(100, 600);
            end else begin
                mode_cycles <= mode_cycles - 1;
            end
            if (!long_hold_done && tri_taken == 60) begin
                long_hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 1) != 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        span_t e;
        if (aresetn && m_valid && m_ready) begin
            spans_seen <= spans_seen + 1;
            if (m_truncated) trunc_seen <= trunc_seen + 1;
            if (span_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected span word: row %0d start %0d end %0d",
                             m_row, m_span_start, m_span_end);
            end else begin
                e = span_q.pop_front();
                if (m_row !== e.row || m_span_start !== e.span_start ||
                    m_span_end !== e.span_end || m_last !== e.last ||
                    m_truncated !== e.truncated) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"span mismatch: exp row %0d start %0d end %0d last %0d",
                                  " trunc %0d, got row %0d start %0d end %0d last %0d",
                                  " trunc %0d"},
                                 e.row, e.span_start, e.span_end, e.last, e.truncated,
                                 m_row, m_span_start, m_span_end, m_last, m_truncated);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d spans still expected", span_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int n, bx0, by0;
        s_valid = 1'b0; m_ready = 1'b0;
        s_ax = '0; s_ay = '0; s_bx = '0; s_by = '0; s_cx = '0; s_cy = '0;
        tri_sent = 0; tri_taken = 0; spans_seen = 0; trunc_seen = 0; mismatches = 0;
        idle_cycles = 0; burst_left = 1; gap_left = 0; hold_left = 0;
        stall_mode = 0; mode_cycles = 0; long_hold_done = 0;
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        tri_q.insert(tri_q.size(), make_tri(5, 10, 40, 10, 90, 10, 0));        // flat
        tri_q.insert(tri_q.size(), make_tri(0, 0, 10, 63, 0, 63, 0));          // exactly the cap
        tri_q.insert(tri_q.size(), make_tri(0, 0, 100, 100, 0, 100, 0));       // cap cuts rows
        tri_q.insert(tri_q.size(), make_tri(0, -30, 20, 20, -10, 20, 0));      // rows above zero
        tri_q.insert(tri_q.size(), make_tri(-50, 5, -10, 30, -40, 40, 0));     // left of zero
        tri_q.insert(tri_q.size(), make_tri(-20, 0, 30, 15, -5, 25, 0));       // start clamp
        tri_q.insert(tri_q.size(), make_tri(2040, 0, 2047, 10, 2000, 20, 0));  // right edge
        tri_q.insert(tri_q.size(), make_tri(2047, 2047, -2048, -2048, 2047, -2048, 0));
        tri_q.insert(tri_q.size(), make_tri(-2048, 2047, 2047, 2000, -2048, 1990, 0));
        tri_q.insert(tri_q.size(), make_tri(-2048, -2048, 2047, 2047, -2048, 2047, 0));
        tri_q.insert(tri_q.size(), make_tri(10, 30, 20, 0, 5, 10, 0));         // top is second
        tri_q.insert(tri_q.size(), make_tri(10, 30, 40, 20, 25, 0, 0));        // top is third
        tri_q.insert(tri_q.size(), make_tri(30, 0, 0, 20, 60, 20, 0));         // flat bottom
        tri_q.insert(tri_q.size(), make_tri(0, 0, 60, 0, 30, 25, 0));          // flat top
        tri_q.insert(tri_q.size(), make_tri(50, 0, 0, 40, 10, 20, 0));         // edges swap
        tri_q.insert(tri_q.size(), make_tri(7, 7, 7, 7, 7, 7, 1));             // single point
        tri_q.insert(tri_q.size(), make_tri(0, 0, 1, 1, 0, 1, 0));
        tri_q.insert(tri_q.size(), make_tri(3, 4, 3, 9, 3, 20, 0));            // zero width

        // random, mostly small triangles near the visible area
        for (n = 0; n < 440; n++) begin
            if (n % 20 == 19) begin
                tri_q.insert(tri_q.size(),
                             make_tri($urandom_range(0, 4095) - 2048,
                                      $urandom_range(0, 4095) - 2048,
                                      $urandom_range(0, 4095) - 2048,
                                      $urandom_range(0, 4095) - 2048,
                                      $urandom_range(0, 4095) - 2048,
                                      $urandom_range(0, 4095) - 2048, n == 219));
            end else begin
                bx0 = $urandom_range(0, 3) == 0 ? $urandom_range(1900, 2000)
                                                : $urandom_range(0, 300);
                by0 = $urandom_range(0, 7) == 0 ? $urandom_range(1950, 1990)
                                                : $urandom_range(0, 200);
                tri_q.insert(tri_q.size(),
                             make_tri(small_coord(bx0), small_coord(by0),
                                      small_coord(bx0), small_coord(by0),
                                      small_coord(bx0), small_coord(by0), 0));
            end
        end
        tri_total = tri_q.size();

        wait (tri_taken == tri_total && span_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("%0d triangles in, %0d spans out (%0d truncated), %0d mismatches",
                 tri_taken, spans_seen, trunc_seen, mismatches);
        $display("covered flat, capped, off-screen, edge-swap and full-range triangles");
        if (mismatches == 0 && span_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tsf_pkg.sv
rtl/core/tsf_div.sv
rtl/core/tsf_datapath.sv
rtl/core/tsf_ctrl.sv
rtl/core/triangle_scanline_span_fill.sv
tb/tb_triangle_scanline_span_fill.sv
